[rtl/arq_rt_pkg.sv]
// Package for the retransmit tracker: item types, command and result codes,
// sequencer states and shared helper functions.
// Depends on nothing; the front end, back end and top level import it.
package arq_rt_pkg;

  localparam int SLOTS_DEF  = 16;
  localparam int MAX_OUT    = 16;
  localparam int EMIT_W     = $clog2(MAX_OUT + 1);
  localparam int CMDQ_DEPTH = 2;
  localparam int OUTQ_DEPTH = 4;

  localparam logic [15:0] TIMEOUT_RESET = 16'd4;

  // Command codes on the input channel.
  localparam logic [1:0] CMD_SEND = 2'd0;
  localparam logic [1:0] CMD_ACK  = 2'd1;
  localparam logic [1:0] CMD_SCAN = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  // Result kinds.
  localparam logic [2:0] KIND_ACCEPTED = 3'd0;
  localparam logic [2:0] KIND_FULL     = 3'd1;
  localparam logic [2:0] KIND_ACKED    = 3'd2;
  localparam logic [2:0] KIND_IGNORED  = 3'd3;
  localparam logic [2:0] KIND_RETX     = 3'd4;
  localparam logic [2:0] KIND_NONE     = 3'd5;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] now;
    logic [7:0]  ack_slot;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [31:0] sequence_res;
    logic [31:0] transmissions;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_ACK  = 2'd1,
    OP_SCAN = 2'd2
  } op_e;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    op_e         op;
    logic [31:0] now;
    logic        ack_ok;
    logic [7:0]  ack_slot;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_ACK_RD   = 2'd1,
    ST_SCAN     = 2'd2,
    ST_SCAN_END = 2'd3
  } back_state_e;

  function automatic logic [31:0] sat_inc(input logic [31:0] val);
    return (val == 32'hFFFF_FFFF) ? val : val + 32'd1;
  endfunction

endpackage

[rtl/arq_rt_fifo.sv]
// Small register FIFO used for the command queue and the result queue.
// Depends on nothing.
module arq_rt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[rtl/arq_rt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module arq_rt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

[rtl/arq_rt_front.sv]
// Front end: accepts input transactions, decodes the command and checks the
// acknowledged slot range, then queues the result for the back end.
// Depends on arq_rt_pkg and arq_rt_fifo.
module arq_rt_front #(
  parameter int SLOTS = arq_rt_pkg::SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  arq_rt_pkg::in_item_t in_item,
  output logic                in_full,
  output logic                cmd_valid,
  output arq_rt_pkg::cmd_t    cmd_item,
  input  logic                cmd_pop
);
  import arq_rt_pkg::*;

  cmd_t             dec;
  logic             enq;
  logic             q_empty;
  logic [$bits(cmd_t)-1:0] q_rdata;

  always_comb begin
    dec.now      = in_item.now;
    dec.ack_slot = in_item.ack_slot;
    dec.ack_ok   = ({1'b0, in_item.ack_slot} < 9'(SLOTS));
    dec.op       = OP_SEND;
    enq          = 1'b1;
    unique case (in_item.cmd)
      CMD_SEND: dec.op = OP_SEND;
      CMD_ACK:  dec.op = OP_ACK;
      CMD_SCAN: dec.op = OP_SCAN;
      default: begin
        // An unknown command is taken and dropped; it has no result.
        enq = 1'b0;
      end
    endcase
  end

  arq_rt_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push && enq),
    .wdata (dec),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign cmd_valid = !q_empty;
  assign cmd_item  = cmd_t'(q_rdata);

endmodule

[rtl/arq_rt_back.sv]
// Back end: slot table, sequence and transmission counters, the sequencer that
// carries out sends, acks and slot-by-slot scans, and the result queue.
// Depends on arq_rt_pkg, arq_rt_ram and arq_rt_fifo.
module arq_rt_back #(
  parameter int SLOTS  = arq_rt_pkg::SLOTS_DEF,
  parameter int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [15:0]          cfg_data,
  output logic                 cfg_ready,
  input  logic                 cmd_valid,
  input  arq_rt_pkg::cmd_t     cmd_item,
  output logic                 cmd_pop,
  input  logic                 out_pop,
  output logic                 out_empty,
  output arq_rt_pkg::out_item_t out_item
);
  import arq_rt_pkg::*;

  function automatic logic [3:0] slot_field(input logic [SLOT_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[3:0];
  endfunction

  back_state_e       state_r, state_nxt;
  logic [SLOTS-1:0]  busy_r, busy_nxt;
  logic [31:0]       next_seq_r, next_seq_nxt;
  logic [31:0]       tx_r, tx_nxt;
  logic [15:0]       timeout_r;
  logic [31:0]       now_r, now_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [EMIT_W-1:0] emitted_r, emitted_nxt;
  logic              hold_valid_r, hold_valid_nxt;
  out_item_t         hold_r, hold_nxt;

  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic [SLOT_W-1:0] ack_idx;
  logic              ack_hit;
  logic              idle_go;
  logic              qualify;
  logic              scan_stall;
  logic              idx_last;

  logic              time_we, seq_we;
  logic [SLOT_W-1:0] waddr, raddr;
  logic [31:0]       time_wdata, seq_wdata;
  logic [31:0]       time_rdata, seq_rdata;

  logic              outq_push, outq_full;
  out_item_t         outq_item;
  logic [$bits(out_item_t)-1:0] outq_rdata;

  assign cfg_ready = 1'b1;

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  assign ack_idx    = cmd_item.ack_slot[SLOT_W-1:0];
  assign ack_hit    = cmd_item.ack_ok && busy_r[ack_idx];
  assign idle_go    = (state_r == ST_IDLE) && cmd_valid && !outq_full;
  assign idx_last   = (idx_r == SLOT_W'(SLOTS - 1));
  // Age is taken modulo 2^32; the read data belongs to slot idx_r.
  assign qualify    = busy_r[idx_r] && ((now_r - time_rdata) >= {16'b0, timeout_r}) &&
                      (emitted_r < EMIT_W'(MAX_OUT));
  assign scan_stall = qualify && hold_valid_r && outq_full;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (idle_go) begin
          unique case (cmd_item.op)
            OP_ACK:  if (ack_hit) state_nxt = ST_ACK_RD;
            OP_SCAN: state_nxt = ST_SCAN;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ACK_RD: begin
        if (!outq_full) state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (!scan_stall && idx_last) state_nxt = ST_SCAN_END;
      end
      ST_SCAN_END: begin
        if (!outq_full) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop        = 1'b0;
    outq_push      = 1'b0;
    outq_item      = '0;
    time_we        = 1'b0;
    seq_we         = 1'b0;
    waddr          = idx_r;
    time_wdata     = now_r;
    seq_wdata      = next_seq_r;
    raddr          = idx_r;
    busy_nxt       = busy_r;
    next_seq_nxt   = next_seq_r;
    tx_nxt         = tx_r;
    now_nxt        = now_r;
    idx_nxt        = idx_r;
    emitted_nxt    = emitted_r;
    hold_valid_nxt = hold_valid_r;
    hold_nxt       = hold_r;
    unique case (state_r)
      ST_IDLE: begin
        if (idle_go) begin
          cmd_pop = 1'b1;
          unique case (cmd_item.op)
            OP_SEND: begin
              outq_push = 1'b1;
              outq_item.last = 1'b1;
              if (free_found) begin
                busy_nxt[free_idx]      = 1'b1;
                time_we                 = 1'b1;
                seq_we                  = 1'b1;
                waddr                   = free_idx;
                time_wdata              = cmd_item.now;
                next_seq_nxt            = next_seq_r + 32'd1;
                tx_nxt                  = sat_inc(tx_r);
                outq_item.kind          = KIND_ACCEPTED;
                outq_item.slot          = slot_field(free_idx);
                outq_item.sequence_res  = next_seq_r;
                outq_item.transmissions = sat_inc(tx_r);
              end else begin
                outq_item.kind          = KIND_FULL;
                outq_item.transmissions = tx_r;
              end
            end
            OP_ACK: begin
              if (ack_hit) begin
                busy_nxt[ack_idx] = 1'b0;
                idx_nxt           = ack_idx;
                raddr             = ack_idx;
              end else begin
                outq_push               = 1'b1;
                outq_item.kind          = KIND_IGNORED;
                outq_item.transmissions = tx_r;
                outq_item.last          = 1'b1;
              end
            end
            OP_SCAN: begin
              now_nxt        = cmd_item.now;
              idx_nxt        = '0;
              raddr          = '0;
              emitted_nxt    = '0;
              hold_valid_nxt = 1'b0;
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      ST_ACK_RD: begin
        if (!outq_full) begin
          outq_push               = 1'b1;
          outq_item.kind          = KIND_ACKED;
          outq_item.slot          = slot_field(idx_r);
          outq_item.sequence_res  = seq_rdata;
          outq_item.transmissions = tx_r;
          outq_item.last          = 1'b1;
        end
      end
      ST_SCAN: begin
        if (!scan_stall) begin
          if (qualify) begin
            // The previous retransmit is released only once a later one is
            // known, so that the final one can carry the last flag.
            outq_push              = hold_valid_r;
            outq_item              = hold_r;
            time_we                = 1'b1;
            tx_nxt                 = sat_inc(tx_r);
            hold_valid_nxt         = 1'b1;
            hold_nxt.kind          = KIND_RETX;
            hold_nxt.slot          = slot_field(idx_r);
            hold_nxt.sequence_res  = seq_rdata;
            hold_nxt.transmissions = sat_inc(tx_r);
            hold_nxt.last          = 1'b0;
            emitted_nxt            = emitted_r + 1'b1;
          end
          if (!idx_last) begin
            idx_nxt = idx_r + 1'b1;
            raddr   = idx_r + 1'b1;
          end
        end
      end
      ST_SCAN_END: begin
        if (!outq_full) begin
          outq_push = 1'b1;
          if (hold_valid_r) begin
            outq_item      = hold_r;
            outq_item.last = 1'b1;
          end else begin
            outq_item.kind          = KIND_NONE;
            outq_item.transmissions = tx_r;
            outq_item.last          = 1'b1;
          end
          hold_valid_nxt = 1'b0;
        end
      end
      default: begin
        hold_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      busy_r       <= '0;
      next_seq_r   <= '0;
      tx_r         <= '0;
      timeout_r    <= TIMEOUT_RESET;
      hold_valid_r <= 1'b0;
      emitted_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      busy_r       <= busy_nxt;
      next_seq_r   <= next_seq_nxt;
      tx_r         <= tx_nxt;
      hold_valid_r <= hold_valid_nxt;
      emitted_r    <= emitted_nxt;
      if (cfg_valid && cfg_ready) begin
        timeout_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    now_r  <= now_nxt;
    idx_r  <= idx_nxt;
    hold_r <= hold_nxt;
  end

  arq_rt_ram #(
    .WIDTH (32),
    .DEPTH (SLOTS),
    .AW    (SLOT_W)
  ) u_time_ram (
    .clk   (clk),
    .we    (time_we),
    .waddr (waddr),
    .wdata (time_wdata),
    .raddr (raddr),
    .rdata (time_rdata)
  );

  arq_rt_ram #(
    .WIDTH (32),
    .DEPTH (SLOTS),
    .AW    (SLOT_W)
  ) u_seq_ram (
    .clk   (clk),
    .we    (seq_we),
    .waddr (waddr),
    .wdata (seq_wdata),
    .raddr (raddr),
    .rdata (seq_rdata)
  );

  arq_rt_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (outq_push),
    .wdata (outq_item),
    .full  (outq_full),
    .pop   (out_pop),
    .rdata (outq_rdata),
    .empty (out_empty)
  );

  assign out_item = out_item_t'(outq_rdata);

endmodule

[rtl/arq_retransmit_tracker_top.sv]
// Top level of the retransmit tracker: front end, back end and checks.
// Depends on arq_rt_pkg, arq_rt_front and arq_rt_back.
//
// Usage. Commands enter through a queue-style port: a transaction is taken at
// a rising edge with in_push high and in_full low. Each send, ack or scan is
// answered by one or more results, read through out_empty / out_pop; the
// oldest result sits on out_item while out_empty is low. Unknown commands are
// taken and dropped without a result. The retransmit timeout is written on
// the cfg channel (cfg_valid with cfg_ready); the user must write it only
// while no command is open, which the block itself does not enforce. The
// front end queues two decoded commands. An ack that frees a held slot
// first reads the sequence RAM. A scan visits one slot per cycle through
// the time and sequence RAM read ports while a full result queue does not
// stall it, then sends its final result. Results reach out_item through
// the result queue. Reset (synchronous, rst_n low) frees every slot, clears
// both counters and both queues and sets the timeout to 4. When the receiver
// stops popping, the result queue fills, the sequencer waits, the command
// queue fills and in_full rises; nothing is lost.
module arq_retransmit_tracker_top #(
  parameter int SLOTS = arq_rt_pkg::SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  arq_rt_pkg::in_item_t  in_item,
  output logic                  in_full,
  output logic                  out_empty,
  input  logic                  out_pop,
  output arq_rt_pkg::out_item_t out_item,
  input  logic                  cfg_valid,
  input  logic [15:0]           cfg_data,
  output logic                  cfg_ready
);
  import arq_rt_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd_item;

  arq_rt_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .cmd_valid (cmd_valid),
    .cmd_item  (cmd_item),
    .cmd_pop   (cmd_pop)
  );

  arq_rt_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .cmd_valid (cmd_valid),
    .cmd_item  (cmd_item),
    .cmd_pop   (cmd_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

  // The back end never takes a command that is not there.
  a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("command popped from an empty queue");

  // Only retransmit results can be followed by more results of the same scan.
  a_last_on_single: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.kind != KIND_RETX) |-> out_item.last)
    else $error("single-result transaction without last flag");

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

endmodule
